// ===== hw/rtl/dpc_pkg.sv =====
// dpc_pkg: shared types and constants of the clamped discrete PID unit.
// No dependencies; used by dpc_err_sel, dpc_core and discrete_pid_clamped_unit.
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int unsigned COEF_W  = 24;
    localparam int unsigned SAMP_W  = 16;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned IDX_W   = 3;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_COEF_NEWEST = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COEF_MIDDLE = 3'd1;
    localparam logic [IDX_W-1:0] CFG_COEF_OLDEST = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_MIN     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OUT_MAX     = 3'd4;

    localparam logic [OUT_W-1:0] OUT_MAX_RST = 16'd32768;

    // round-half-up bias for the Q.28 to Q.15 step
    localparam int unsigned RND_SHIFT = 13;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_newest;
        logic signed [COEF_W-1:0] coef_middle;
        logic signed [COEF_W-1:0] coef_oldest;
        logic        [OUT_W-1:0]  out_min;
        logic        [OUT_W-1:0]  out_max;
    } t_cfg;

endpackage

// ===== hw/rtl/dpc_err_sel.sv =====
// dpc_err_sel: forms the error sample, direct or reference minus measurement.
// Depends on dpc_pkg.
`timescale 1ns / 1ps

module dpc_err_sel (
    input  logic                               i_kind,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_error_in,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_reference,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_measurement,
    output logic signed [dpc_pkg::SAMP_W-1:0]  o_err
);

    logic signed [dpc_pkg::SAMP_W:0] diff;
    logic signed [dpc_pkg::SAMP_W-1:0] diff_sat;

    assign diff = $signed({i_reference[dpc_pkg::SAMP_W-1], i_reference})
                - $signed({i_measurement[dpc_pkg::SAMP_W-1], i_measurement});

    // saturate when the two top bits disagree
    always_comb begin
        if (diff[dpc_pkg::SAMP_W] == diff[dpc_pkg::SAMP_W-1]) begin
            diff_sat = diff[dpc_pkg::SAMP_W-1:0];
        end else if (diff[dpc_pkg::SAMP_W]) begin
            diff_sat = {1'b1, {(dpc_pkg::SAMP_W-1){1'b0}}};
        end else begin
            diff_sat = {1'b0, {(dpc_pkg::SAMP_W-1){1'b1}}};
        end
    end

    assign o_err = i_kind ? diff_sat : i_error_in;

endmodule

// ===== hw/rtl/dpc_core.sv =====
// dpc_core: three-tap multiply-accumulate, rounding, output history and clamp.
// Holds error and output history. Depends on dpc_pkg.
`timescale 1ns / 1ps

module dpc_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  dpc_pkg::t_cfg                      i_cfg,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_err,
    output logic        [dpc_pkg::OUT_W-1:0]   o_drive
);

    localparam int unsigned PROD_W = dpc_pkg::COEF_W + dpc_pkg::SAMP_W;
    localparam int unsigned ACC_W  = PROD_W + 2;
    localparam int unsigned RND_W  = ACC_W - dpc_pkg::RND_SHIFT;
    localparam int unsigned SUM_W  = RND_W + 1;

    logic signed [dpc_pkg::SAMP_W-1:0] r_err_h0, r_err_h1;
    logic        [dpc_pkg::OUT_W-1:0]  r_out_h0, r_out_h1;

    logic signed [PROD_W-1:0] prod_new, prod_mid, prod_old;
    logic signed [ACC_W-1:0]  acc, acc_rnd;
    logic signed [RND_W-1:0]  acc_q15;
    logic signed [SUM_W-1:0]  sum, lim_min, lim_max;

    assign prod_new = i_cfg.coef_newest * i_err;
    assign prod_mid = i_cfg.coef_middle * r_err_h1;
    assign prod_old = i_cfg.coef_oldest * r_err_h0;

    assign acc     = ACC_W'(prod_new) + ACC_W'(prod_mid) + ACC_W'(prod_old);
    assign acc_rnd = acc + ACC_W'(1 << (dpc_pkg::RND_SHIFT - 1));
    assign acc_q15 = acc_rnd[ACC_W-1:dpc_pkg::RND_SHIFT];

    assign sum     = $signed({acc_q15[RND_W-1], acc_q15})
                   + $signed({{(SUM_W-dpc_pkg::OUT_W){1'b0}}, r_out_h0});
    assign lim_min = $signed({{(SUM_W-dpc_pkg::OUT_W){1'b0}}, i_cfg.out_min});
    assign lim_max = $signed({{(SUM_W-dpc_pkg::OUT_W){1'b0}}, i_cfg.out_max});

    // upper limit wins, so an inverted window still gives a defined answer
    always_comb begin
        if (sum >= lim_max) begin
            o_drive = i_cfg.out_max;
        end else if (sum > lim_min) begin
            o_drive = sum[dpc_pkg::OUT_W-1:0];
        end else begin
            o_drive = i_cfg.out_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_h0 <= '0;
            r_err_h1 <= '0;
            r_out_h0 <= '0;
            r_out_h1 <= '0;
        end else if (i_adv) begin
            r_err_h0 <= r_err_h1;
            r_err_h1 <= i_err;
            r_out_h0 <= r_out_h1;
            r_out_h1 <= o_drive;
        end
    end

endmodule

// ===== hw/rtl/discrete_pid_clamped_unit.sv =====
// discrete_pid_clamped_unit: top level of the clamped Tustin-form PID controller.
// Instantiates dpc_err_sel and dpc_core; depends on dpc_pkg.
`timescale 1ns / 1ps

// One request is one controller sample. The error is either i_error_in or
// i_reference - i_measurement saturated to 16 bits (i_kind selects). The new
// drive is the drive from two samples back plus coef_newest, coef_middle and
// coef_oldest (Q11.13, already scaled by 1/2T) times the newest three errors,
// rounded half up to Q1.15 and clamped to [out_min, out_max]; when the window
// is inverted a sum at or above out_max gives out_max, anything else out_min.
// The block has two register stages: an input register and a drive register,
// with the multiply-accumulate and clamp between them. A sample is accepted
// every cycle unless a stalled drive holds the input register; its drive is
// loaded into the drive register as the sample advances, and the input
// register takes the next sample in while a finished drive waits. Error and
// drive histories advance as each sample passes the arithmetic stage, so the
// dependence on the previous samples is resolved with no stall. Write the
// configuration registers (0..4, higher indexes ignored) only while idle.

module discrete_pid_clamped_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dpc_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [dpc_pkg::CFG_W-1:0]          i_cfg_wdata,
    // sample request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_error_in,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_reference,
    input  logic signed [dpc_pkg::SAMP_W-1:0]  i_measurement,
    // drive result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic        [dpc_pkg::OUT_W-1:0]   o_drive
);

    dpc_pkg::t_cfg r_cfg;

    // input register
    logic                              r_in_vld;
    logic                              r_kind;
    logic signed [dpc_pkg::SAMP_W-1:0] r_error_in, r_reference, r_measurement;

    // drive register
    logic                              r_out_vld;
    logic        [dpc_pkg::OUT_W-1:0]  r_drive;

    logic                              in_acc;
    logic                              adv;
    logic signed [dpc_pkg::SAMP_W-1:0] err;
    logic        [dpc_pkg::OUT_W-1:0]  n_drive;

    // advance the held request when the drive register is empty or draining
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;

    // configuration decode: drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_newest <= '0;
            r_cfg.coef_middle <= '0;
            r_cfg.coef_oldest <= '0;
            r_cfg.out_min     <= '0;
            r_cfg.out_max     <= dpc_pkg::OUT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpc_pkg::CFG_COEF_NEWEST: begin
                    r_cfg.coef_newest <= i_cfg_wdata;
                end
                dpc_pkg::CFG_COEF_MIDDLE: begin
                    r_cfg.coef_middle <= i_cfg_wdata;
                end
                dpc_pkg::CFG_COEF_OLDEST: begin
                    r_cfg.coef_oldest <= i_cfg_wdata;
                end
                dpc_pkg::CFG_OUT_MIN: begin
                    r_cfg.out_min <= i_cfg_wdata[dpc_pkg::OUT_W-1:0];
                end
                dpc_pkg::CFG_OUT_MAX: begin
                    r_cfg.out_max <= i_cfg_wdata[dpc_pkg::OUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register: valid under reset, payload captured on accept only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind        <= i_kind;
            r_error_in    <= i_error_in;
            r_reference   <= i_reference;
            r_measurement <= i_measurement;
        end
    end

    dpc_err_sel u_err_sel (
        .i_kind        (r_kind),
        .i_error_in    (r_error_in),
        .i_reference   (r_reference),
        .i_measurement (r_measurement),
        .o_err         (err)
    );

    dpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_err   (err),
        .o_drive (n_drive)
    );

    // drive register: load on advance, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drive <= n_drive;
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("drive valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_in_vld)
        else $error("accepted request lost from input register");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced sample lost from drive register");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> r_out_vld)
        else $error("stalled drive dropped");

endmodule
